@@ src/tsgr_pkg.sv @@
// Shared widths, field offsets and constants for the tempo-synced gain ramp.
`timescale 1ns / 1ps
`default_nettype none

package tsgr_pkg;

  // Item kinds carried in tuser.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  // Field widths.
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned BEATS_W  = 16;
  localparam int unsigned TEMPO_W  = 14;
  localparam int unsigned SR_W     = 18;

  // Input word layout, lowest bit first.
  localparam int unsigned IN_LEFT_LSB  = 0;
  localparam int unsigned IN_RIGHT_LSB = IN_LEFT_LSB + SAMPLE_W;
  localparam int unsigned IN_ID_LSB    = IN_RIGHT_LSB + SAMPLE_W;
  localparam int unsigned IN_MODE_LSB  = IN_ID_LSB + ID_W;
  localparam int unsigned IN_MUTE_LSB  = IN_MODE_LSB + MODE_W;
  localparam int unsigned IN_GAIN_LSB  = IN_MUTE_LSB + 1;
  localparam int unsigned IN_BEATS_LSB = IN_GAIN_LSB + GAIN_W;
  localparam int unsigned IN_TEMPO_LSB = IN_BEATS_LSB + BEATS_W;
  localparam int unsigned IN_USED_W    = IN_TEMPO_LSB + TEMPO_W;
  localparam int unsigned IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output word layout, lowest bit first.
  localparam int unsigned OUT_USED_W = 2 * SAMPLE_W + GAIN_W + 1 + MODE_W;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // Gain arithmetic: Q1.15 gain with 24 extra fraction bits.
  localparam int unsigned EXTRA_FRAC = 24;
  localparam int unsigned ACC_W      = GAIN_W + EXTRA_FRAC;
  localparam int unsigned STEP_W     = ACC_W + 1;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd32768;
  localparam logic [ACC_W-1:0]  ACC_UNITY  = {GAIN_UNITY, {EXTRA_FRAC{1'b0}}};

  // Tempo handling, Q10.4.
  localparam logic [TEMPO_W-1:0] TEMPO_MIN     = 14'd16;
  localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT = 14'd1920;
  localparam int unsigned DIVSR_W = TEMPO_W + 2;

  localparam logic [SR_W-1:0] SR_RESET = 18'd48000;

  // Shared multiplier operand widths (signed).
  localparam int unsigned MUL_A_W = SAMPLE_W + 1;
  localparam int unsigned MUL_B_W = SR_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

endpackage

`default_nettype wire

@@ src/tsgr_div.sv @@
// Restoring divider that produces one quotient bit per clock.
`timescale 1ns / 1ps
`default_nettype none

module tsgr_div #(
  parameter int unsigned DVD_W = 40,
  parameter int unsigned DVS_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             fits;

  always_comb begin
    trial     = {rem_q, dvd_q[DVD_W-1]};
    fits      = trial >= {1'b0, dvs_q};
    trial_sub = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // The dividend register shifts out at the top and takes quotient bits in.
        rem_q <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        dvd_q <= {dvd_q[DVD_W-2:0], fits};
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

@@ src/tempo_synced_gain_ramp_core.sv @@
// Top level of the tempo-synced stereo gain ramp: sequencer, gain state and output register.
`timescale 1ns / 1ps
`default_nettype none

// Stereo fader driven by one stream of words: tuser low marks a stereo sample pair,
// tuser high a control packet. Every sample pair gives exactly one output word and a
// packet gives none. A packet whose id is not below the last accepted one sets the
// mode, the mute flag and the target gain, and starts a linear ramp lasting
// beats * 60 / tempo * sample rate samples; a tempo of 1 BPM or less is taken as 120.
// All work goes through one small sequencer that drives a shared multiplier and a
// shared bit-serial divider, and the input is not ready while an item is in flight.
// A sample pair occupies the block through the gain update, left product, right
// product, output load and return to idle, and waits in the output load while the
// output register has not drained. An accepted packet makes two passes of the
// 40-bit divider at one quotient bit per cycle: one for the ramp length and one
// for the step. When the ramp length comes out as zero the second pass is skipped.
// A packet with a stale id is dropped in the cycle it is accepted, and the input
// is ready again in the next cycle.
// The sample rate register may only be written while the block is idle.

module tempo_synced_gain_ramp_core #(
  parameter int unsigned RAMP_COUNT_BITS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Sample rate register, 18 bits.
  input  wire logic                             cfg_we_i,
  input  wire logic [tsgr_pkg::SR_W-1:0]        cfg_wdata_i,
  // Input words.
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // sample_left[23:0], sample_right[47:24], packet_id[79:48], packet_mode[81:80],
  // packet_mute[82], packet_gain[98:83], packet_beats[114:99], tempo_bpm[128:115]
  input  wire logic [tsgr_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // command
  input  wire logic                             s_axis_tuser_i,
  // Output words.
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // out_left[23:0], out_right[47:24], gain_now[63:48], muted_now[64], mode_now[66:65]
  output logic [tsgr_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o
);

  import tsgr_pkg::*;

  localparam int unsigned RCB = RAMP_COUNT_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PKT_NUM,
    ST_PKT_LEN_GO,
    ST_PKT_LEN_WAIT,
    ST_PKT_STEP_WAIT,
    ST_SMP_GAIN,
    ST_SMP_MUL_L,
    ST_SMP_MUL_R,
    ST_SMP_EMIT
  } state_e;

  state_e                    state_q;
  logic [SR_W-1:0]           sr_q;
  logic [ACC_W-1:0]          acc_q;
  logic [GAIN_W-1:0]         target_q;
  logic signed [STEP_W-1:0]  step_q;
  logic [RCB-1:0]            left_q;
  logic [ID_W-1:0]           last_id_q;
  logic                      mute_q;
  logic [MODE_W-1:0]         mode_q;
  logic [SAMPLE_W-1:0]       smp_l_q;
  logic [SAMPLE_W-1:0]       smp_r_q;
  logic [BEATS_W-1:0]        beats_q;
  logic [DIVSR_W-1:0]        divsr_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [SAMPLE_W-1:0]       res_l_q;
  logic                      neg_q;
  logic                      out_valid_q;
  logic [OUT_DATA_W-1:0]     out_data_q;

  // Unpacked input fields.
  logic [SAMPLE_W-1:0] in_left;
  logic [SAMPLE_W-1:0] in_right;
  logic [ID_W-1:0]     in_id;
  logic [MODE_W-1:0]   in_mode;
  logic                in_mute;
  logic [GAIN_W-1:0]   in_gain;
  logic [BEATS_W-1:0]  in_beats;
  logic [TEMPO_W-1:0]  in_tempo;
  logic [TEMPO_W-1:0]  tempo_eff;
  logic                in_acc;

  always_comb begin
    in_left   = s_axis_tdata_i[IN_LEFT_LSB  +: SAMPLE_W];
    in_right  = s_axis_tdata_i[IN_RIGHT_LSB +: SAMPLE_W];
    in_id     = s_axis_tdata_i[IN_ID_LSB    +: ID_W];
    in_mode   = s_axis_tdata_i[IN_MODE_LSB  +: MODE_W];
    in_mute   = s_axis_tdata_i[IN_MUTE_LSB];
    in_gain   = s_axis_tdata_i[IN_GAIN_LSB  +: GAIN_W];
    in_beats  = s_axis_tdata_i[IN_BEATS_LSB +: BEATS_W];
    in_tempo  = s_axis_tdata_i[IN_TEMPO_LSB +: TEMPO_W];
    // Very slow or missing tempo falls back to 120 BPM.
    tempo_eff = (in_tempo <= TEMPO_MIN) ? TEMPO_DEFAULT : in_tempo;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Shared multiplier. It forms beats * sample rate for a packet, and each channel
  // times the current gain for a sample pair.
  logic [GAIN_W-1:0]         gain_now;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  assign gain_now = acc_q[ACC_W-1 -: GAIN_W];

  always_comb begin
    unique case (state_q)
      ST_PKT_NUM: begin
        mul_a = $signed({{(MUL_A_W - BEATS_W){1'b0}}, beats_q});
        mul_b = $signed({1'b0, sr_q});
      end
      ST_SMP_MUL_R: begin
        mul_a = $signed({smp_r_q[SAMPLE_W-1], smp_r_q});
        mul_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, gain_now});
      end
      default: begin
        mul_a = $signed({smp_l_q[SAMPLE_W-1], smp_l_q});
        mul_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, gain_now});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Ramp length numerator is the product times 15; it stays below 2^38.
  logic [PROD_W+3:0] num_w;
  logic [ACC_W-1:0]  num;

  always_comb begin
    num_w = {prod_q, 4'b0000} - {4'b0000, prod_q};
    num   = num_w[ACC_W-1:0];
  end

  // Shared divider.
  logic             div_start;
  logic [ACC_W-1:0] div_dividend;
  logic [RCB-1:0]   div_divisor;
  logic             div_done;
  logic [ACC_W-1:0] div_quo;

  // Length saturation and the signed gain distance to the target.
  logic [RCB-1:0]           len_sat;
  logic                     len_zero;
  logic [ACC_W-1:0]         target_acc;
  logic [STEP_W-1:0]        diff;
  logic [ACC_W-1:0]         diff_mag;
  logic [STEP_W-1:0]        quo_ext;
  logic signed [STEP_W-1:0] step_new;
  logic signed [STEP_W-1:0] acc_sum;

  always_comb begin
    len_sat    = (|(div_quo >> RCB)) ? {RCB{1'b1}} : div_quo[RCB-1:0];
    len_zero   = (len_sat == '0);
    target_acc = {target_q, {EXTRA_FRAC{1'b0}}};
    diff       = {1'b0, target_acc} - {1'b0, acc_q};
    diff_mag   = diff[STEP_W-1] ? ACC_W'(~diff + 1'b1) : diff[ACC_W-1:0];
    quo_ext    = {1'b0, div_quo};
    step_new   = neg_q ? $signed(~quo_ext + 1'b1) : $signed(quo_ext);
    acc_sum    = $signed({1'b0, acc_q}) + step_q;
  end

  always_comb begin
    div_start    = (state_q == ST_PKT_LEN_GO) ||
                   ((state_q == ST_PKT_LEN_WAIT) && div_done && !len_zero);
    div_dividend = (state_q == ST_PKT_LEN_GO) ? num : diff_mag;
    div_divisor  = (state_q == ST_PKT_LEN_GO) ? RCB'(divsr_q) : len_sat;
  end

  tsgr_div #(
    .DVD_W (ACC_W),
    .DVS_W (RCB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Output register: it frees as soon as the downstream side takes the word.
  logic                out_free;
  logic [SAMPLE_W-1:0] res_r;
  logic [SAMPLE_W-1:0] res_l_out;
  logic [SAMPLE_W-1:0] res_r_out;

  always_comb begin
    out_free  = !out_valid_q || m_axis_tready_i;
    // Arithmetic shift by 15 floors the product, which matches the rounding of the gain.
    res_r     = prod_q[GAIN_W-1 +: SAMPLE_W];
    res_l_out = mute_q ? '0 : res_l_q;
    res_r_out = mute_q ? '0 : res_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sr_q        <= SR_RESET;
      acc_q       <= ACC_UNITY;
      target_q    <= GAIN_UNITY;
      step_q      <= '0;
      left_q      <= '0;
      last_id_q   <= '0;
      mute_q      <= 1'b0;
      mode_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sr_q <= cfg_wdata_i;
      end

      if ((state_q == ST_SMP_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {{OUT_PAD_W{1'b0}}, mode_q, mute_q, gain_now, res_r_out, res_l_out};
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            smp_l_q <= in_left;
            smp_r_q <= in_right;
            beats_q <= in_beats;
            divsr_q <= {tempo_eff, 2'b00};
            if (s_axis_tuser_i == CMD_SAMPLE) begin
              state_q <= ST_SMP_GAIN;
            end else if (in_id >= last_id_q) begin
              // An equal id is still taken; only older ids are dropped.
              last_id_q <= in_id;
              mode_q    <= in_mode;
              mute_q    <= in_mute;
              target_q  <= (in_gain > GAIN_UNITY) ? GAIN_UNITY : in_gain;
              state_q   <= ST_PKT_NUM;
            end
          end
        end
        ST_PKT_NUM: begin
          prod_q  <= mul_p;
          state_q <= ST_PKT_LEN_GO;
        end
        ST_PKT_LEN_GO: begin
          state_q <= ST_PKT_LEN_WAIT;
        end
        ST_PKT_LEN_WAIT: begin
          if (div_done) begin
            if (len_zero) begin
              // A zero-length ramp jumps straight to the target.
              acc_q   <= target_acc;
              step_q  <= '0;
              left_q  <= '0;
              state_q <= ST_IDLE;
            end else begin
              left_q  <= len_sat;
              neg_q   <= diff[STEP_W-1];
              state_q <= ST_PKT_STEP_WAIT;
            end
          end
        end
        ST_PKT_STEP_WAIT: begin
          if (div_done) begin
            step_q  <= step_new;
            state_q <= ST_IDLE;
          end
        end
        ST_SMP_GAIN: begin
          if (left_q != '0) begin
            left_q <= left_q - 1'b1;
            // The last step of a ramp snaps to the target to clear truncation error.
            acc_q  <= (left_q == RCB'(1)) ? target_acc : acc_sum[ACC_W-1:0];
          end else begin
            acc_q <= target_acc;
          end
          state_q <= ST_SMP_MUL_L;
        end
        ST_SMP_MUL_L: begin
          prod_q  <= mul_p;
          state_q <= ST_SMP_MUL_R;
        end
        ST_SMP_MUL_R: begin
          res_l_q <= prod_q[GAIN_W-1 +: SAMPLE_W];
          prod_q  <= mul_p;
          state_q <= ST_SMP_EMIT;
        end
        ST_SMP_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  // The ramp never overshoots, so the gain stays at or below unity.
  a_gain_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= ACC_UNITY)
    else $error("gain accumulator above unity");

  // With no ramp running, the gain sits exactly on its target.
  a_idle_on_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && left_q == '0) |-> acc_q == target_acc)
    else $error("gain off target with no ramp in progress");

  // The divider only finishes while the sequencer is waiting for it.
  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_PKT_LEN_WAIT || state_q == ST_PKT_STEP_WAIT))
    else $error("divider finished outside a wait state");

  // A sample pair cannot leave while an unread word is stalled in the output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i && state_q == ST_SMP_EMIT) |=> state_q == ST_SMP_EMIT)
    else $error("output word overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking stream testbench for the tempo-synced stereo gain ramp core.
`timescale 1ns / 1ps

// The bench drives the core through its input stream with a mix of stereo sample pairs
// and control packets, and checks every output word against its model or a table row.
// It opens with a short table of hand-written words that covers reset state, the sample
// extremes, gain clamping, stale and equal packet ids, the slow-tempo fallback and the
// zero-length jump. A long random part follows, split into phases. Between phases the
// sample rate register is rewritten, always with the core idle, and the idling pattern
// of the two sides changes. In one phase the output side holds off for a long stretch,
// so that the core backs up and stalls its input.
module tb_top;
  import tsgr_pkg::*;

  localparam int unsigned RAMP_BITS       = 32;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned WORDS_PER_PHASE = 205;
  // This is ample for the core to finish a packet and settle.
  localparam int unsigned SETTLE_CYCLES   = 150;
  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned HOLD_PHASE      = 2;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // One input word; the packing below cmd matches tdata, lowest field last.
  typedef struct packed {
    logic                cmd;
    logic [TEMPO_W-1:0]  tempo;
    logic [BEATS_W-1:0]  beats;
    logic [GAIN_W-1:0]   gain;
    logic                mute;
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     id;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] left;
  } fader_item_t;

  // One output word, packed exactly as the used bits of the output tdata.
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                muted;
    logic [GAIN_W-1:0]   gain;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] left;
  } fader_word_t;

  typedef struct {
    fader_item_t item;
    bit          typed;
    fader_word_t want;
  } directed_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [SR_W-1:0]       cfg_wdata_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = CMD_SAMPLE;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // Shared between the stimulus process and the two side processes.
  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned phase_no = 0;
  int unsigned fault_count = 0;
  fader_word_t expected_outputs[$];

  // Our own copy of the fader state and of the sample rate register.
  logic [SR_W-1:0]   fade_rate_hz;
  longint            fade_acc;
  logic [GAIN_W-1:0] fade_target;
  longint            fade_delta;
  longint unsigned   fade_to_go;
  logic [ID_W-1:0]   fade_last_id;
  logic              fade_muted;
  logic [MODE_W-1:0] fade_mode;

  tempo_synced_gain_ramp_core #(
    .RAMP_COUNT_BITS(RAMP_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic fade_reset();
    fade_rate_hz = SR_RESET;
    fade_acc     = longint'(ACC_UNITY);
    fade_target  = GAIN_UNITY;
    fade_delta   = 0;
    fade_to_go   = 0;
    fade_last_id = '0;
    fade_muted   = 1'b0;
    fade_mode    = '0;
  endtask

  // floor(sample * gain / 32768), kept to the 24-bit output field.
  function automatic logic [SAMPLE_W-1:0] scale_by_gain(logic [SAMPLE_W-1:0] s,
                                                        logic [GAIN_W-1:0] g);
    longint prod;
    prod = longint'($signed(s)) * longint'(g);
    prod = prod >>> 15;
    return prod[SAMPLE_W-1:0];
  endfunction

  // A packet that is not stale retargets the ramp; its length is worked out in samples
  // from beats, tempo and sample rate, and a zero length jumps straight to the target.
  function automatic void fade_take_packet(fader_item_t it);
    longint unsigned tempo_q4;
    longint unsigned span;
    longint unsigned span_max;
    longint          goal;
    if (it.id < fade_last_id) return;
    fade_last_id = it.id;
    fade_mode    = it.mode;
    fade_muted   = it.mute;
    fade_target  = (it.gain > GAIN_UNITY) ? GAIN_UNITY : it.gain;
    tempo_q4     = (it.tempo <= TEMPO_MIN) ? 64'(TEMPO_DEFAULT) : 64'(it.tempo);
    span         = 64'(it.beats) * 64'(fade_rate_hz) * 64'd15 / (64'd4 * tempo_q4);
    span_max     = (64'd1 << RAMP_BITS) - 64'd1;
    if (span > span_max) span = span_max;
    goal = longint'(fade_target) << EXTRA_FRAC;
    if (span == 0) begin
      fade_acc   = goal;
      fade_delta = 0;
      fade_to_go = 0;
    end else begin
      fade_to_go = span;
      fade_delta = (goal - fade_acc) / longint'(span);
    end
  endfunction

  function automatic fader_word_t fade_next_word(fader_item_t it);
    fader_word_t w;
    longint      goal;
    longint      whole;
    goal = longint'(fade_target) << EXTRA_FRAC;
    if (fade_to_go > 0) begin
      fade_acc += fade_delta;
      fade_to_go--;
      if (fade_to_go == 0) fade_acc = goal;
    end else begin
      fade_acc = goal;
    end
    whole   = fade_acc >>> EXTRA_FRAC;
    w.gain  = whole[GAIN_W-1:0];
    w.muted = fade_muted;
    w.mode  = fade_mode;
    w.left  = fade_muted ? '0 : scale_by_gain(it.left, w.gain);
    w.right = fade_muted ? '0 : scale_by_gain(it.right, w.gain);
    return w;
  endfunction

  // Advances the model by one accepted word; returns 1 when an output word is due.
  function automatic bit fade_accept(fader_item_t it, output fader_word_t w);
    w = '0;
    if (it.cmd == CMD_PACKET) begin
      fade_take_packet(it);
      return 1'b0;
    end
    w = fade_next_word(it);
    return 1'b1;
  endfunction

  function automatic directed_row_t sample_row(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
    directed_row_t row;
    row.item       = '0;
    row.item.cmd   = CMD_SAMPLE;
    row.item.left  = l;
    row.item.right = r;
    row.typed      = 1'b0;
    row.want       = '0;
    return row;
  endfunction

  function automatic directed_row_t sample_row_known(logic [SAMPLE_W-1:0] l,
                                                    logic [SAMPLE_W-1:0] r,
                                                    logic [SAMPLE_W-1:0] ol,
                                                    logic [SAMPLE_W-1:0] orr,
                                                    logic [GAIN_W-1:0] g,
                                                    logic m, logic [MODE_W-1:0] md);
    directed_row_t row;
    row       = sample_row(l, r);
    row.typed = 1'b1;
    row.want  = '{mode: md, muted: m, gain: g, right: orr, left: ol};
    return row;
  endfunction

  function automatic directed_row_t packet_row(logic [ID_W-1:0] id, logic [MODE_W-1:0] md,
                                              logic m, logic [GAIN_W-1:0] g,
                                              logic [BEATS_W-1:0] b, logic [TEMPO_W-1:0] t);
    directed_row_t row;
    row.item     = '0;
    row.item.cmd = CMD_PACKET;
    row.item.id  = id;
    row.item.mode  = md;
    row.item.mute  = m;
    row.item.gain  = g;
    row.item.beats = b;
    row.item.tempo = t;
    row.typed    = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = 24'h7FFFFF;
      1:       s = 24'h800000;
      2:       s = 24'hFFFFFF;
      default: s = SAMPLE_W'($urandom());
    endcase
    return s;
  endfunction

  // Mostly in-order packet ids, so that most packets take effect, with some repeats,
  // stale ids and wild jumps. Short ramps dominate so that many of them run to the end.
  function automatic fader_item_t random_item();
    fader_item_t     it;
    int unsigned     pick;
    longint unsigned bumped;
    it.cmd   = ($urandom_range(0, 99) < 12) ? CMD_PACKET : CMD_SAMPLE;
    it.left  = random_sample();
    it.right = random_sample();
    it.mode  = MODE_W'($urandom());
    it.mute  = ($urandom_range(0, 99) < 15);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      bumped = 64'(fade_last_id) + 64'($urandom_range(0, 3));
      it.id  = (bumped > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : bumped[ID_W-1:0];
    end else if (pick < 80) begin
      it.id = fade_last_id;
    end else if (pick < 90) begin
      it.id = (fade_last_id == 0) ? '0 : $urandom_range(0, fade_last_id - 1);
    end else if (pick < 98) begin
      it.id = $urandom();
    end else begin
      it.id = 32'hFFFF_FFFF;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10)      it.gain = GAIN_UNITY;
    else if (pick < 20) it.gain = '0;
    else if (pick < 50) it.gain = GAIN_W'($urandom_range(0, 65535));
    else                it.gain = GAIN_W'($urandom_range(0, 32768));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.tempo = TEMPO_W'($urandom_range(8192, 16383));
      it.beats = BEATS_W'($urandom_range(0, 4));
    end else if (pick < 75) begin
      it.tempo = TEMPO_W'($urandom_range(0, 16));
      it.beats = BEATS_W'($urandom_range(0, 8));
    end else begin
      it.tempo = TEMPO_W'($urandom_range(0, 16383));
      it.beats = BEATS_W'($urandom_range(0, 65535));
    end
    return it;
  endfunction

  // Offers one word at the falling edge, after any idle gap, and returns once the core
  // has taken it. tvalid stays high into the next word unless that word idles first.
  task automatic send_item(fader_item_t it);
    int unsigned gap_pct;
    int unsigned gap;
    gap_pct = (idle_mode == IDLE_SENDER) ? 76 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    gap = 0;
    while ($urandom_range(0, 99) < gap_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = it.cmd;
    s_axis_tdata_i  = {{(IN_DATA_W - IN_USED_W){1'b0}}, it[IN_USED_W-1:0]};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic offer_and_predict(fader_item_t it, bit typed, fader_word_t want);
    fader_word_t w;
    send_item(it);
    if (fade_accept(it, w)) expected_outputs.push_back(typed ? want : w);
  endtask

  task automatic wait_until_drained();
    while (expected_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    directed_row_t   rows[$];
    fader_item_t     it;
    logic [SR_W-1:0] rate;
    fade_reset();

    // Unity gain after reset, so the first words pass through untouched.
    rows.push_back(sample_row_known(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                                    GAIN_UNITY, 1'b0, 2'd0));
    rows.push_back(sample_row_known(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001,
                                    GAIN_UNITY, 1'b0, 2'd0));
    rows.push_back(sample_row_known('0, '0, '0, '0, GAIN_UNITY, 1'b0, 2'd0));
    // An id equal to the reset id is taken; zero beats jumps straight to zero gain.
    rows.push_back(packet_row(32'd0, 2'd3, 1'b0, 16'd0, 16'd0, 14'd0));
    rows.push_back(sample_row_known(24'h7FFFFF, 24'h800000, '0, '0, 16'd0, 1'b0, 2'd3));
    // A gain above unity is clamped; the mute flag forces zero output.
    rows.push_back(packet_row(32'd10, 2'd1, 1'b1, 16'hFFFF, 16'd0, 14'd16383));
    rows.push_back(sample_row_known(24'd123456, 24'hF60A0F, '0, '0, GAIN_UNITY, 1'b1, 2'd1));
    // A stale id changes nothing.
    rows.push_back(packet_row(32'd9, 2'd2, 1'b0, 16'd0, 16'd0, 14'd0));
    rows.push_back(sample_row_known(24'h800000, 24'h7FFFFF, '0, '0, GAIN_UNITY, 1'b1, 2'd1));
    // A repeated id is taken. Half gain shows the rounding towards minus infinity.
    rows.push_back(packet_row(32'd10, 2'd2, 1'b0, 16'd16384, 16'd0, 14'd16));
    rows.push_back(sample_row_known(24'h800000, 24'h7FFFFF, 24'hC00000, 24'h3FFFFF,
                                    16'd16384, 1'b0, 2'd2));
    rows.push_back(sample_row_known(24'hFFFFFF, 24'h000001, 24'hFFFFFF, '0,
                                    16'd16384, 1'b0, 2'd2));
    // One beat at the fallback tempo of 120: a long ramp back up to unity.
    rows.push_back(packet_row(32'd11, 2'd0, 1'b0, GAIN_UNITY, 16'd256, 14'd16));
    rows.push_back(sample_row(24'd5000000, 24'hB3B4C0));
    rows.push_back(sample_row(24'h800000, 24'h7FFFFF));
    // A short ramp down to zero at the fastest tempo, run part of the way.
    rows.push_back(packet_row(32'd12, 2'd1, 1'b0, 16'd0, 16'd3, 14'd16383));
    rows.push_back(sample_row(24'h7FFFFF, 24'h800000));
    rows.push_back(sample_row(24'h7FFFFF, 24'h800000));
    rows.push_back(sample_row(24'h400000, 24'hC00000));
    rows.push_back(sample_row(24'h123456, 24'hEDCBA9));
    // The longest beat count at the slowest tempo that is not replaced.
    rows.push_back(packet_row(32'd13, 2'd2, 1'b0, GAIN_UNITY, 16'hFFFF, 14'd17));
    rows.push_back(sample_row(24'h7FFFFF, 24'h800000));
    rows.push_back(packet_row(32'h8000_0000, 2'd3, 1'b0, 16'd20000, 16'd2, 14'd16383));
    rows.push_back(sample_row(24'h7FFFFF, 24'h800000));
    rows.push_back(sample_row(24'h800000, 24'h7FFFFF));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) offer_and_predict(rows[i].item, rows[i].typed, rows[i].want);

    for (int unsigned p = 0; p < PHASES; p++) begin
      // The first phase runs at the reset sample rate; later ones rewrite it while idle.
      if (p > 0) begin
        case (p)
          1:       rate = '0;
          2:       rate = '1;
          3:       rate = 18'd8000;
          4:       rate = 18'd192000;
          default: rate = SR_W'($urandom_range(8000, 192000));
        endcase
        wait_until_drained();
        @(negedge clk_i);
        cfg_we_i     = 1'b1;
        cfg_wdata_i  = rate;
        fade_rate_hz = rate;
        @(negedge clk_i);
        cfg_we_i = 1'b0;
      end
      phase_no  = p;
      idle_mode = idle_mode_e'(p % 4);
      repeat (WORDS_PER_PHASE) begin
        it = random_item();
        offer_and_predict(it, 1'b0, '0);
      end
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
    end

    wait_until_drained();
    if (fault_count == 0 && expected_outputs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Output side: random stalls by phase, plus one long hold-off so the core backs up.
  always @(negedge clk_i) begin : drain_side
    int unsigned hold_left;
    bit          hold_done;
    int unsigned stall_pct;
    if (phase_no == HOLD_PHASE && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    stall_pct = (idle_mode == IDLE_RECEIVER) ? 76 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i = 1'b0;
    end else begin
      m_axis_tready_i = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report_fault(string what, fader_word_t want, fader_word_t got);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%0t %s: expected L=%0d R=%0d gain=%0d mute=%0b mode=%0d", $realtime, what,
               $signed(want.left), $signed(want.right), want.gain, want.muted, want.mode);
      $display("%0t %s:      got L=%0d R=%0d gain=%0d mute=%0b mode=%0d", $realtime, what,
               $signed(got.left), $signed(got.right), got.gain, got.muted, got.mode);
    end
  endtask

  // Every word taken from the output is compared with the oldest one still owed.
  always @(posedge clk_i) begin : output_check
    fader_word_t got;
    fader_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[OUT_USED_W-1:0];
      if (expected_outputs.size() == 0) begin
        report_fault("unexpected word", '0, got);
      end else begin
        want = expected_outputs.pop_front();
        if (got.left !== want.left || got.right !== want.right || got.gain !== want.gain ||
            got.muted !== want.muted || got.mode !== want.mode) begin
          report_fault("word mismatch", want, got);
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither side moves a word.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

endmodule

@@ filelist.f @@
src/tsgr_pkg.sv
src/tsgr_div.sv
src/tempo_synced_gain_ramp_core.sv
tb/tb_top.sv
